// ----- src/biquad_cascade_iir_filter_unit_macros.svh -----
// Assertion macros shared by the biquad cascade filter RTL.
// Included by the modules that carry concurrent assertions.
`ifndef BIQUAD_CASCADE_IIR_FILTER_UNIT_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_UNIT_MACROS_SVH

// Checked on every aclk edge outside reset.
`define BCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every aclk edge, reset included.
`define BCQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/bcq_pkg.sv -----
// Package for the biquad cascade filter: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bcq_pkg;

    localparam int MAX_SECTIONS = 32;
    localparam int SEC_W        = $clog2(MAX_SECTIONS);
    localparam int CNT_W        = SEC_W + 1;
    localparam int NCOEF        = 5;
    localparam int SEL_W        = 3;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int STATE_W      = 32;
    localparam int COEF_FRAC    = COEF_W - 4;
    localparam int PROD_W       = COEF_W + STATE_W;
    localparam int ACC_W        = PROD_W + 4;
    localparam int CFG_W        = 6;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd4;

    typedef enum logic {
        KIND_FILTER = 1'b0,
        KIND_COEF   = 1'b1
    } bcq_kind_t;

    typedef struct packed {
        bcq_kind_t               kind;
        logic [SAMPLE_W-1:0]     sample;
        logic [SEC_W-1:0]        sec;
        logic [SEL_W-1:0]        sel;
        logic [COEF_W-1:0]       value;
    } bcq_item_t;

    typedef struct packed {
        logic      valid;
        bcq_item_t item;
    } bcq_queue_t;

endpackage

// ----- src/bcq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bcq_front.sv -----
// Front end: accepts input beats, drops bad coefficient writes, queues the rest.
// Depends on bcq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "biquad_cascade_iir_filter_unit_macros.svh"

module bcq_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,
    input  logic                              s_tuser,
    output bcq_pkg::bcq_queue_t               q_head,
    input  logic                              q_pop
);
    import bcq_pkg::*;

    bcq_item_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    q_count_reg, q_count_next;
    bcq_item_t            item_in;
    logic                 addr_ok;
    logic                 accept;
    logic                 push;

    always_comb begin
        item_in.kind   = (s_tuser == CMD_COEF) ? KIND_COEF : KIND_FILTER;
        item_in.sample = s_tdata[SAMPLE_W-1:0];
        item_in.sec    = s_tdata[28:24];
        item_in.sel    = s_tdata[31:29];
        item_in.value  = s_tdata[63:32];
    end

    assign addr_ok  = (CNT_W'(item_in.sec) < CNT_W'(MAX_SECTIONS)) &&
                      (item_in.sel < SEL_W'(NCOEF));
    assign s_tready = (q_count_reg != QCNT_W'(QDEPTH));
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && ((item_in.kind == KIND_FILTER) || addr_ok);

    always_comb begin
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_count_next = q_count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign q_head.valid = (q_count_reg != '0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    `BCQ_ASSERT(a_q_no_overflow, (q_count_reg == QCNT_W'(QDEPTH)) |-> !push, "queue overflow")
    `BCQ_ASSERT(a_q_no_underflow, q_pop |-> (q_count_reg != '0), "queue underflow")

endmodule

// ----- src/bcq_back.sv -----
// Back end: coefficient writes and the section sequencer with one shared MAC.
// Depends on bcq_pkg, bcq_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "biquad_cascade_iir_filter_unit_macros.svh"

module bcq_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bcq_pkg::bcq_queue_t               q_head,
    output logic                              q_pop,
    input  logic [bcq_pkg::CFG_W-1:0]         active_sections,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // sample_out[23:0]
    output logic                              m_tuser    // clipped
);
    import bcq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_WB   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam int HIST_W = 4 * STATE_W;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            sec_reg, sec_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [SEL_W-1:0]            step_reg, step_next;
    logic signed [STATE_W-1:0]   x_reg, x_next;
    logic                        clip_reg, clip_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        prod_sub_reg;
    logic                        prod_vld_reg, prod_vld_next;
    logic                        m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]         m_data_reg;
    logic                        m_user_reg;

    logic [MAX_SECTIONS-1:0]     cvld_reg [NCOEF];
    logic [NCOEF-1:0]            cvld_q_reg;
    logic [MAX_SECTIONS-1:0]     hvld_reg;
    logic                        hvld_q_reg;

    logic                        coef_wr;
    logic                        rd_en;
    logic                        hist_we;
    logic [COEF_W-1:0]           coef_rd [NCOEF];
    logic signed [COEF_W-1:0]    coef_op [NCOEF];
    logic [HIST_W-1:0]           hist_rd;
    logic [HIST_W-1:0]           hist_op;
    logic [HIST_W-1:0]           hist_wdata;
    logic signed [STATE_W-1:0]   x1, x2, y1, y2;
    logic signed [COEF_W-1:0]    mul_a;
    logic signed [STATE_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-COEF_FRAC-1:0] shifted;
    logic                        y_ovf;
    logic signed [STATE_W-1:0]   y_sat;
    logic                        out_ovf;
    logic [SAMPLE_W-1:0]         out_sat;
    logic                        out_load;
    logic [CNT_W-1:0]            n_clamped;

    assign q_pop   = (state_reg == ST_IDLE) && q_head.valid;
    assign coef_wr = q_pop && (q_head.item.kind == KIND_COEF);
    assign rd_en   = (state_reg == ST_READ);
    assign hist_we = (state_reg == ST_WB);

    for (genvar i = 0; i < NCOEF; i++) begin : g_coef
        bcq_ram #(
            .WIDTH (COEF_W),
            .DEPTH (MAX_SECTIONS)
        ) u_coef_ram (
            .aclk  (aclk),
            .we    (coef_wr && (q_head.item.sel == SEL_W'(i))),
            .waddr (q_head.item.sec),
            .wdata (q_head.item.value),
            .re    (rd_en),
            .raddr (sec_reg[SEC_W-1:0]),
            .rdata (coef_rd[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cvld_reg[i] <= '0;
            end else if (coef_wr && (q_head.item.sel == SEL_W'(i))) begin
                cvld_reg[i][q_head.item.sec] <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (rd_en) begin
                cvld_q_reg[i] <= cvld_reg[i][sec_reg[SEC_W-1:0]];
            end
        end

        assign coef_op[i] = cvld_q_reg[i] ? $signed(coef_rd[i]) : '0;
    end

    bcq_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_SECTIONS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (sec_reg[SEC_W-1:0]),
        .wdata (hist_wdata),
        .re    (rd_en),
        .raddr (sec_reg[SEC_W-1:0]),
        .rdata (hist_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvld_reg <= '0;
        end else if (hist_we) begin
            hvld_reg[sec_reg[SEC_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hvld_q_reg <= hvld_reg[sec_reg[SEC_W-1:0]];
        end
    end

    // history row: {y2, y1, x2, x1}
    assign hist_op = hvld_q_reg ? hist_rd : '0;
    assign x1 = $signed(hist_op[STATE_W-1:0]);
    assign x2 = $signed(hist_op[2*STATE_W-1:STATE_W]);
    assign y1 = $signed(hist_op[3*STATE_W-1:2*STATE_W]);
    assign y2 = $signed(hist_op[4*STATE_W-1:3*STATE_W]);

    always_comb begin
        mul_a = coef_op[0];
        mul_b = x_reg;
        unique case (step_reg)
            SEL_B0: begin mul_a = coef_op[0]; mul_b = x_reg; end
            SEL_B1: begin mul_a = coef_op[1]; mul_b = x1;    end
            SEL_B2: begin mul_a = coef_op[2]; mul_b = x2;    end
            SEL_A1: begin mul_a = coef_op[3]; mul_b = y1;    end
            SEL_A2: begin mul_a = coef_op[4]; mul_b = y2;    end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MAC) begin
            prod_reg     <= mul_a * mul_b;
            prod_sub_reg <= (step_reg == SEL_A1) || (step_reg == SEL_A2);
        end
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign shifted  = acc_reg[ACC_W-1:COEF_FRAC];
    assign y_ovf    = !((&shifted[ACC_W-COEF_FRAC-1:STATE_W-1]) ||
                        !(|shifted[ACC_W-COEF_FRAC-1:STATE_W-1]));
    assign y_sat    = y_ovf ? (shifted[ACC_W-COEF_FRAC-1] ? STATE_MIN : STATE_MAX)
                            : shifted[STATE_W-1:0];
    assign hist_wdata = {y1, y_sat, x1, x_reg};

    assign out_ovf  = !((&x_reg[STATE_W-1:SAMPLE_W-1]) || !(|x_reg[STATE_W-1:SAMPLE_W-1]));
    assign out_sat  = out_ovf ? (x_reg[STATE_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                              : x_reg[SAMPLE_W-1:0];
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign n_clamped = (active_sections > CFG_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                               : CNT_W'(active_sections);

    always_comb begin
        state_next    = state_reg;
        sec_next      = sec_reg;
        n_next        = n_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        clip_next     = clip_reg;
        acc_next      = acc_reg;
        prod_vld_next = prod_vld_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop && (q_head.item.kind == KIND_FILTER)) begin
                    x_next    = STATE_W'($signed(q_head.item.sample));
                    clip_next = 1'b0;
                    sec_next  = '0;
                    n_next    = n_clamped;
                    state_next = (n_clamped == '0) ? ST_OUT : ST_READ;
                end
            end
            ST_READ: begin
                acc_next      = ROUND_BIAS;
                step_next     = SEL_B0;
                prod_vld_next = 1'b0;
                state_next    = ST_MAC;
            end
            ST_MAC: begin
                if (prod_vld_reg) begin
                    acc_next = prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
                end
                prod_vld_next = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == SEL_A2) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next   = prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
                state_next = ST_WB;
            end
            ST_WB: begin
                x_next     = y_sat;
                clip_next  = clip_reg | y_ovf;
                sec_next   = sec_reg + 1'b1;
                state_next = (sec_reg + 1'b1 == n_reg) ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sec_reg      <= '0;
            n_reg        <= '0;
            step_reg     <= SEL_B0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sec_reg      <= sec_next;
            n_reg        <= n_next;
            step_reg     <= step_next;
            prod_vld_reg <= prod_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        clip_reg <= clip_next;
        acc_reg  <= acc_next;
        if (out_load) begin
            m_data_reg <= out_sat;
            m_user_reg <= clip_reg | out_ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `BCQ_ASSERT(a_sec_in_range, (state_reg != ST_IDLE) |-> (sec_reg <= n_reg), "section past count")
    `BCQ_ASSERT(a_wb_in_range, hist_we |-> (sec_reg < n_reg), "history write past count")
    `BCQ_ASSERT(a_out_waits, (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_OUT), "result overwritten")

endmodule

// ----- src/biquad_cascade_iir_filter_unit.sv -----
// A sample passes through N sections to the output register, N = active sections (max 32).
// The back end takes no new beat until the last result is loaded; each section uses one shared 32x32 MAC
//   for five products, plus a memory read, an accumulate and a write-back step.
// Coefficient beats are written from the idle state in the back end and give no output beat.
// Reset (aresetn low, synchronous) clears the queue, sequencer, output valid flag and the
//   valid bits of coefficient and history memories; active_sections returns to 4.
`timescale 1ns / 1ps

module biquad_cascade_iir_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_in[23:0], section_index[28:24],
                                   // coef_select[31:29], coef_value[63:32]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_out[23:0]
    output logic        m_tuser,   // clipped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcq_pkg::*;

    logic [CFG_W-1:0] active_reg;
    logic             cfg_wr;
    bcq_queue_t       q_head;
    logic             q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = !paddr[2] ? APB_DW'(active_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            active_reg <= pwdata[CFG_W-1:0];
        end
    end

    bcq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    bcq_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .active_sections (active_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule
